### hw/rtl/stl_pkg.sv
// Shared types, constants and helpers for the steering torque limiter.
// No dependencies; used by every file under hw/rtl.
package stl_pkg;

    localparam int WINDOW_DEPTH = 6;

    localparam int RAW_W   = 16;
    localparam int CMD_W   = 16;
    localparam int OUT_W   = 14;
    localparam int MEAS_W  = 18;
    localparam int CALC_W  = 20;
    localparam int PROD_W  = 25;
    localparam int MAG_W   = 23;
    localparam int QUOT_W  = 17;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 72;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // divide by 100 as multiply by ceil(2^30 / 100); exact for magnitudes below 2^23
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 99) / 100);

    localparam logic signed [CALC_W-1:0] OUT_MIN = -CALC_W'(8192);
    localparam logic signed [CALC_W-1:0] OUT_MAX = CALC_W'(8191);

    localparam logic signed [MEAS_W-1:0] MEAS_TOP = {1'b0, {(MEAS_W-1){1'b1}}};
    localparam logic signed [MEAS_W-1:0] MEAS_BOT = {1'b1, {(MEAS_W-1){1'b0}}};

    localparam logic [7:0]  EPS_FACTOR_RST = 8'd73;
    localparam logic [11:0] TORQUE_MAX_RST = 12'd1500;
    localparam logic [7:0]  RATE_UP_RST    = 8'd10;
    localparam logic [7:0]  RATE_DOWN_RST  = 8'd20;
    localparam logic [11:0] ERROR_MAX_RST  = 12'd350;

    typedef enum logic [2:0] {
        REG_EPS_FACTOR = 3'd0,
        REG_TORQUE_MAX = 3'd1,
        REG_RATE_UP    = 3'd2,
        REG_RATE_DOWN  = 3'd3,
        REG_ERROR_MAX  = 3'd4
    } reg_idx_t;

    typedef enum logic [0:0] {
        OP_MEAS = 1'b0,
        OP_CMD  = 1'b1
    } op_t;

    typedef struct packed {
        logic [7:0]  eps_factor;
        logic [11:0] torque_max;
        logic [7:0]  rate_up;
        logic [7:0]  rate_down;
        logic [11:0] error_max;
    } cfg_t;

    function automatic logic signed [CALC_W-1:0] smin(
        input logic signed [CALC_W-1:0] a,
        input logic signed [CALC_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [CALC_W-1:0] smax(
        input logic signed [CALC_W-1:0] a,
        input logic signed [CALC_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [CALC_W-1:0] sclip(
        input logic signed [CALC_W-1:0] v,
        input logic signed [CALC_W-1:0] lo,
        input logic signed [CALC_W-1:0] hi
    );
        return smax(lo, smin(v, hi));
    endfunction

endpackage

### hw/rtl/stl_cfg.sv
// APB register bank for the torque limiter settings.
// Depends on stl_pkg.
module stl_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [stl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [stl_pkg::APB_DATA_W-1:0]    prdata,
    output stl_pkg::cfg_t                     cfg
);

    stl_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    idx;

    assign idx   = paddr[stl_pkg::APB_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eps_factor <= stl_pkg::EPS_FACTOR_RST;
            cfg_reg.torque_max <= stl_pkg::TORQUE_MAX_RST;
            cfg_reg.rate_up    <= stl_pkg::RATE_UP_RST;
            cfg_reg.rate_down  <= stl_pkg::RATE_DOWN_RST;
            cfg_reg.error_max  <= stl_pkg::ERROR_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                stl_pkg::REG_EPS_FACTOR: cfg_reg.eps_factor <= pwdata[7:0];
                stl_pkg::REG_TORQUE_MAX: cfg_reg.torque_max <= pwdata[11:0];
                stl_pkg::REG_RATE_UP:    cfg_reg.rate_up    <= pwdata[7:0];
                stl_pkg::REG_RATE_DOWN:  cfg_reg.rate_down  <= pwdata[7:0];
                stl_pkg::REG_ERROR_MAX:  cfg_reg.error_max  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            stl_pkg::REG_EPS_FACTOR: prdata = {24'd0, cfg_reg.eps_factor};
            stl_pkg::REG_TORQUE_MAX: prdata = {20'd0, cfg_reg.torque_max};
            stl_pkg::REG_RATE_UP:    prdata = {24'd0, cfg_reg.rate_up};
            stl_pkg::REG_RATE_DOWN:  prdata = {24'd0, cfg_reg.rate_down};
            stl_pkg::REG_ERROR_MAX:  prdata = {20'd0, cfg_reg.error_max};
            default:                 prdata = '0;
        endcase
    end

endmodule

### hw/rtl/stl_cell.sv
// One entry of the measured torque window: shift register tap plus one
// link of the running min/max chain. Depends on stl_pkg.
module stl_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 shift,
    input  logic signed [stl_pkg::MEAS_W-1:0]    din,
    output logic signed [stl_pkg::MEAS_W-1:0]    dout,
    input  logic signed [stl_pkg::MEAS_W-1:0]    min_in,
    input  logic signed [stl_pkg::MEAS_W-1:0]    max_in,
    output logic signed [stl_pkg::MEAS_W-1:0]    min_out,
    output logic signed [stl_pkg::MEAS_W-1:0]    max_out
);

    logic signed [stl_pkg::MEAS_W-1:0] entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= din;
        end
    end

    assign dout    = entry_reg;
    assign min_out = (entry_reg < min_in) ? entry_reg : min_in;
    assign max_out = (entry_reg > max_in) ? entry_reg : max_in;

endmodule

### hw/rtl/stl_cmd_limit.sv
// Command clipping: error band around the newest measurement, then the
// asymmetric rate limit around the last output, then output saturation.
// Depends on stl_pkg.
module stl_cmd_limit (
    input  logic signed [stl_pkg::CMD_W-1:0]     command,
    input  logic signed [stl_pkg::MEAS_W-1:0]    meas,
    input  logic signed [stl_pkg::OUT_W-1:0]     last,
    input  stl_pkg::cfg_t                        cfg,
    output logic signed [stl_pkg::OUT_W-1:0]     limited
);

    localparam int W = stl_pkg::CALC_W;

    logic signed [W-1:0] cmd_w, meas_w, last_w;
    logic signed [W-1:0] e_w, t_w, up_w, dn_w;
    logic signed [W-1:0] band_hi, band_lo, val_a;
    logic signed [W-1:0] rate_hi, rate_lo, val_b, val_c;

    always_comb
    begin
        cmd_w  = W'(command);
        meas_w = W'(meas);
        last_w = W'(last);
        e_w    = W'($signed({1'b0, cfg.error_max}));
        t_w    = W'($signed({1'b0, cfg.torque_max}));
        up_w   = W'($signed({1'b0, cfg.rate_up}));
        dn_w   = W'($signed({1'b0, cfg.rate_down}));

        band_hi = stl_pkg::smin(stl_pkg::smax(meas_w + e_w, e_w), t_w);
        band_lo = stl_pkg::smax(stl_pkg::smin(meas_w - e_w, -e_w), -t_w);
        val_a   = stl_pkg::sclip(cmd_w, band_lo, band_hi);

        // magnitude growth is bounded by rate_up, shrinkage by rate_down
        if (last_w > 0)
        begin
            rate_lo = stl_pkg::smax(last_w - dn_w, -up_w);
            rate_hi = last_w + up_w;
        end
        else
        begin
            rate_lo = last_w - up_w;
            rate_hi = stl_pkg::smin(last_w + dn_w, up_w);
        end
        val_b = stl_pkg::sclip(val_a, rate_lo, rate_hi);
        val_c = stl_pkg::sclip(val_b, stl_pkg::OUT_MIN, stl_pkg::OUT_MAX);
    end

    assign limited = val_c[stl_pkg::OUT_W-1:0];

endmodule

### hw/rtl/steer_torque_limiter.sv
// Top level of the steering torque limiter: stream ports, APB settings,
// window cell chain and command limiter. Depends on stl_pkg, stl_cfg,
// stl_cell, stl_cmd_limit.
//
// Input items arrive on s_* (s_tuser = opcode: 0 measurement, 1 command).
// A measurement is scaled by eps_factor/100 (toward zero) and shifted into
// the window; a command is clipped and rate limited and becomes the new
// last output. Every item yields exactly one result item on m_*.
// An item passes stage 1, stage 2 and the output register to m_tvalid.
// Throughput: one item per cycle while m_tready is high; the scaling
// multiply is registered ahead of the state update, and the state update
// and window min/max chain are consecutive stages; items go back to back.
// Ready flows backward combinationally: when m_tready is low the output
// register holds and the two earlier stages still fill, then s_tready
// drops; s_tready is high whenever the output register is empty.
// Reset (rst_n low, asynchronous) clears the window to zeros, the last
// output to zero, all valid flags, and loads the default settings.
// Settings are to be written through APB while the block is idle; the
// block itself does not enforce it. pready is tied high.
module steer_torque_limiter #(
    parameter int WINDOW_DEPTH = stl_pkg::WINDOW_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [stl_pkg::S_DATA_W-1:0]      s_tdata,   // eps_raw[15:0], command[31:16]
    input  logic                              s_tuser,   // opcode[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // limited_torque[13:0], latest_measured[31:14], window_min[49:32],
    // window_max[67:50], zero[71:68]
    output logic [stl_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tuser,   // result_kind[0]
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [stl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [stl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int MW = stl_pkg::MEAS_W;

    stl_pkg::cfg_t cfg;

    // stage 1: captured item and raw scaled product
    logic                                   valid1_reg;
    stl_pkg::op_t                           op1_reg;
    logic signed [stl_pkg::PROD_W-1:0]      prod1_reg;
    logic signed [stl_pkg::CMD_W-1:0]       cmd1_reg;

    // stage 2: state updated, result pending readout
    logic                                   valid2_reg;
    logic                                   kind2_reg;
    logic signed [stl_pkg::OUT_W-1:0]       last_output_reg;

    // output register
    logic                                   out_valid_reg;
    logic [stl_pkg::M_DATA_W-1:0]           out_data_reg;
    logic                                   out_kind_reg;

    logic adv_out, s2_free, adv1, accept, shift_en, cmd_en;

    logic                                   prod_neg;
    logic [stl_pkg::MAG_W-1:0]              prod_mag;
    logic [stl_pkg::MAG_W+stl_pkg::RECIP_W-1:0] quot_full;
    logic [stl_pkg::QUOT_W-1:0]             quot;
    logic signed [MW-1:0]                   scaled;
    logic signed [stl_pkg::OUT_W-1:0]       limited;

    logic signed [MW-1:0] win_val  [WINDOW_DEPTH];
    logic signed [MW-1:0] min_link [WINDOW_DEPTH+1];
    logic signed [MW-1:0] max_link [WINDOW_DEPTH+1];
    logic signed [MW-1:0] win_min_m1, win_max_p1;

    assign pready = 1'b1;

    stl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign adv_out  = valid2_reg && (!out_valid_reg || m_tready);
    assign s2_free  = !valid2_reg || adv_out;
    assign adv1     = valid1_reg && s2_free;
    assign s_tready = !valid1_reg || adv1;
    assign accept   = s_tvalid && s_tready;
    assign shift_en = adv1 && (op1_reg == stl_pkg::OP_MEAS);
    assign cmd_en   = adv1 && (op1_reg == stl_pkg::OP_CMD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op1_reg   <= stl_pkg::op_t'(s_tuser);
            prod1_reg <= $signed(s_tdata[15:0]) * $signed({1'b0, cfg.eps_factor});
            cmd1_reg  <= $signed(s_tdata[31:16]);
        end
    end

    // truncating divide by 100 on the magnitude, sign restored afterwards
    always_comb
    begin
        prod_neg  = prod1_reg[stl_pkg::PROD_W-1];
        prod_mag  = prod_neg ? stl_pkg::MAG_W'(-prod1_reg)
                             : stl_pkg::MAG_W'(prod1_reg);
        quot_full = prod_mag * stl_pkg::RECIP_100;
        quot      = quot_full[stl_pkg::RECIP_SHIFT +: stl_pkg::QUOT_W];
        scaled    = prod_neg ? -MW'(quot) : MW'(quot);
    end

    stl_cmd_limit u_cmd_limit (
        .command (cmd1_reg),
        .meas    (win_val[0]),
        .last    (last_output_reg),
        .cfg     (cfg),
        .limited (limited)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg      <= 1'b0;
            last_output_reg <= '0;
        end
        else
        begin
            if (s2_free)
            begin
                valid2_reg <= adv1;
            end
            if (cmd_en)
            begin
                last_output_reg <= limited;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            kind2_reg <= op1_reg;
        end
    end

    assign min_link[0] = stl_pkg::MEAS_TOP;
    assign max_link[0] = stl_pkg::MEAS_BOT;

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        logic signed [MW-1:0] cell_din;

        if (i == 0)
        begin : g_head
            assign cell_din = scaled;
        end
        else
        begin : g_tail
            assign cell_din = win_val[i-1];
        end

        stl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift_en),
            .din     (cell_din),
            .dout    (win_val[i]),
            .min_in  (min_link[i]),
            .max_in  (max_link[i]),
            .min_out (min_link[i+1]),
            .max_out (max_link[i+1])
        );
    end

    assign win_min_m1 = min_link[WINDOW_DEPTH] - MW'(1);
    assign win_max_p1 = max_link[WINDOW_DEPTH] + MW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            out_kind_reg <= kind2_reg;
            out_data_reg <= {4'd0, win_max_p1, win_min_m1, win_val[0], last_output_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

### hw/rtl/stl_chk.sv
// Port-level checker for steer_torque_limiter, attached by bind.
// Depends on stl_pkg for port widths.
module stl_chk (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [stl_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              m_tuser
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // newest entry lies strictly inside the widened window bounds
    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[49:32]) < $signed(m_tdata[31:14]))
                  && ($signed(m_tdata[31:14]) < $signed(m_tdata[67:50])))
        else $error("window bounds do not enclose newest measurement");

    // with the output register empty nothing can block the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // pad bits above the last field stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:68] == 4'd0)
        else $error("nonzero pad bits in result");

endmodule

bind steer_torque_limiter stl_chk u_stl_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
